// ===== sv/srtf_pkg.sv =====
// Shared types and constants for the SRTF schedule simulator.
// No dependencies; imported by the top level, the compare unit and the checker.
package srtf_pkg;

    localparam int DEFAULT_MAX_PROCESSES = 16;

    localparam int ARR_W      = 12;
    localparam int BUR_W      = 8;
    localparam int IDX_OUT_W  = 4;
    localparam int COMP_OUT_W = 13;
    localparam int TIME_OUT_W = 12;

    localparam int ARR_MAX = (1 << ARR_W) - 1;
    localparam int BUR_MAX = (1 << BUR_W) - 1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_TICK,
        ST_SCAN,
        ST_SCAN_END,
        ST_UPDATE,
        ST_EMIT_RD,
        ST_EMIT_WR
    } srtf_state_t;

    typedef struct packed {
        logic found;
        logic has_next;
    } pick_flags_t;

endpackage

// ===== sv/srtf_schedule_simulator.sv =====
// Channel | Dir | Handshake         | Payload
// in      | in  | in_valid/in_ready | arrival_time, burst_time, last_process
// out     | out | out_valid/out_ready| process_index, completion_time, turnaround_time,
//         |     |                   | waiting_time, last_result
// Loading takes one cycle per process; the transfer with last_process starts the run.
// Each simulated tick makes one RAM read per stored process through the shared compare
// unit, then an update step. Idle stretches collapse to one tick.
// Results leave one at a time through the output register; in_ready is high
// again as soon as the last result is loaded into that register.
// Reset clears the sequencer and counters; the stores need no clearing pass.
// Depends on srtf_pkg, srtf_ram and srtf_pick.
module srtf_schedule_simulator #(
    parameter int MAX_PROCESSES = srtf_pkg::DEFAULT_MAX_PROCESSES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [srtf_pkg::ARR_W-1:0]      arrival_time,
    input  logic [srtf_pkg::BUR_W-1:0]      burst_time,
    input  logic                            last_process,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [srtf_pkg::IDX_OUT_W-1:0]  process_index,
    output logic [srtf_pkg::COMP_OUT_W-1:0] completion_time,
    output logic [srtf_pkg::TIME_OUT_W-1:0] turnaround_time,
    output logic [srtf_pkg::TIME_OUT_W-1:0] waiting_time,
    output logic                            last_result
);
    import srtf_pkg::*;

    localparam int IDX_W = $clog2(MAX_PROCESSES);
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
    localparam int CLK_W = $clog2(ARR_MAX + 1 + MAX_PROCESSES * BUR_MAX);

    srtf_state_t state_reg, state_next;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      done_reg;
    logic [CLK_W-1:0]      clock_reg;
    logic [IDX_W-1:0]      scan_idx_reg;
    logic [IDX_W-1:0]      emit_idx_reg;
    logic                  cand_valid_reg;
    logic [IDX_W-1:0]      cand_idx_reg;

    logic                  out_valid_reg;
    logic [IDX_OUT_W-1:0]  out_idx_reg;
    logic [COMP_OUT_W-1:0] out_comp_reg;
    logic [TIME_OUT_W-1:0] out_tat_reg;
    logic [TIME_OUT_W-1:0] out_wt_reg;
    logic                  out_last_reg;

    // control
    logic                  in_fire;
    logic                  store_ok;
    logic                  load_we;
    logic [IDX_W-1:0]      last_idx;
    logic                  scan_last;
    logic                  emit_last;
    logic                  out_load;
    logic                  run_done;
    logic                  pick_clear;
    logic                  retire;
    logic [BUR_W-1:0]      burst_adj;

    // RAM ports
    logic [IDX_W-1:0]      arr_raddr;
    logic [ARR_W-1:0]      arr_rdata;
    logic [BUR_W-1:0]      bur_rdata;
    logic                  rem_we;
    logic [IDX_W-1:0]      rem_waddr;
    logic [BUR_W-1:0]      rem_wdata;
    logic [BUR_W-1:0]      rem_rdata;
    logic [CLK_W-1:0]      comp_rdata;
    logic [CLK_W-1:0]      clock_inc;

    // compare unit
    pick_flags_t           pflags;
    logic [IDX_W-1:0]      best_idx;
    logic [BUR_W-1:0]      best_rem;
    logic [ARR_W-1:0]      next_arr;

    logic [CLK_W-1:0]      tat_full;
    logic [TIME_OUT_W-1:0] tat_trim;

    assign in_ready  = (state_reg == ST_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign store_ok  = (count_reg < CNT_W'(MAX_PROCESSES));
    assign load_we   = in_fire && store_ok;
    assign burst_adj = (burst_time == '0) ? BUR_W'(1) : burst_time;
    assign last_idx  = IDX_W'(count_reg - CNT_W'(1));
    assign scan_last = (scan_idx_reg == last_idx);
    assign emit_last = (emit_idx_reg == last_idx);
    assign run_done  = (done_reg == count_reg);
    assign clock_inc = clock_reg + CLK_W'(1);
    assign out_load  = (state_reg == ST_EMIT_WR) && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && last_process)
                begin
                    state_next = ST_TICK;
                end
            end
            ST_TICK:
            begin
                state_next = run_done ? ST_EMIT_RD : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END: state_next = ST_UPDATE;
            ST_UPDATE:   state_next = ST_TICK;
            ST_EMIT_RD:  state_next = ST_EMIT_WR;
            ST_EMIT_WR:
            begin
                if (out_load)
                begin
                    state_next = emit_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:     state_next = ST_LOAD;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        pick_clear = (state_reg == ST_TICK);
        retire     = (state_reg == ST_UPDATE) && pflags.found && (best_rem == BUR_W'(1));
        arr_raddr  = ((state_reg == ST_EMIT_RD) || (state_reg == ST_EMIT_WR)) ?
                     emit_idx_reg : scan_idx_reg;
        rem_we     = load_we || ((state_reg == ST_UPDATE) && pflags.found);
        if (state_reg == ST_UPDATE)
        begin
            rem_waddr = best_idx;
            rem_wdata = best_rem - BUR_W'(1);
        end
        else
        begin
            rem_waddr = count_reg[IDX_W-1:0];
            rem_wdata = burst_adj;
        end
    end

    srtf_ram #(.WIDTH(ARR_W), .DEPTH(MAX_PROCESSES)) u_arr_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (arrival_time),
        .raddr (arr_raddr),
        .rdata (arr_rdata)
    );

    srtf_ram #(.WIDTH(BUR_W), .DEPTH(MAX_PROCESSES)) u_bur_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (burst_adj),
        .raddr (emit_idx_reg),
        .rdata (bur_rdata)
    );

    srtf_ram #(.WIDTH(BUR_W), .DEPTH(MAX_PROCESSES)) u_rem_ram (
        .clk   (clk),
        .we    (rem_we),
        .waddr (rem_waddr),
        .wdata (rem_wdata),
        .raddr (scan_idx_reg),
        .rdata (rem_rdata)
    );

    srtf_ram #(.WIDTH(CLK_W), .DEPTH(MAX_PROCESSES)) u_comp_ram (
        .clk   (clk),
        .we    (retire),
        .waddr (best_idx),
        .wdata (clock_inc),
        .raddr (emit_idx_reg),
        .rdata (comp_rdata)
    );

    srtf_pick #(.IDX_W(IDX_W), .CLK_W(CLK_W)) u_pick (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (pick_clear),
        .cand_valid (cand_valid_reg),
        .cand_idx   (cand_idx_reg),
        .cand_arr   (arr_rdata),
        .cand_rem   (rem_rdata),
        .sim_clock  (clock_reg),
        .flags      (pflags),
        .best_idx   (best_idx),
        .best_rem   (best_rem),
        .next_arr   (next_arr)
    );

    assign tat_full = comp_rdata - CLK_W'(arr_rdata);
    assign tat_trim = tat_full[TIME_OUT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            done_reg       <= '0;
            clock_reg      <= '0;
            scan_idx_reg   <= '0;
            emit_idx_reg   <= '0;
            cand_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cand_valid_reg <= (state_reg == ST_SCAN);

            if (load_we)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (out_load && emit_last)
            begin
                count_reg <= '0;
            end

            if (retire)
            begin
                done_reg <= done_reg + CNT_W'(1);
            end
            else if (out_load && emit_last)
            begin
                done_reg <= '0;
            end

            // advance one tick, or jump straight to the next arrival when idle
            if (state_reg == ST_UPDATE)
            begin
                if (!pflags.found && pflags.has_next)
                begin
                    clock_reg <= CLK_W'(next_arr);
                end
                else
                begin
                    clock_reg <= clock_inc;
                end
            end
            else if (out_load && emit_last)
            begin
                clock_reg <= '0;
            end

            if (state_reg == ST_TICK)
            begin
                scan_idx_reg <= '0;
            end
            else if ((state_reg == ST_SCAN) && !scan_last)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end

            if (state_reg == ST_TICK)
            begin
                emit_idx_reg <= '0;
            end
            else if (out_load && !emit_last)
            begin
                emit_idx_reg <= emit_idx_reg + IDX_W'(1);
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cand_idx_reg <= scan_idx_reg;
        if (out_load)
        begin
            out_idx_reg  <= IDX_OUT_W'(emit_idx_reg);
            out_comp_reg <= comp_rdata[COMP_OUT_W-1:0];
            out_tat_reg  <= tat_trim;
            out_wt_reg   <= tat_trim - TIME_OUT_W'(bur_rdata);
            out_last_reg <= emit_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign process_index   = out_idx_reg;
    assign completion_time = out_comp_reg;
    assign turnaround_time = out_tat_reg;
    assign waiting_time    = out_wt_reg;
    assign last_result     = out_last_reg;

endmodule

// ===== sv/srtf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for every per-process store.
module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/srtf_pick.sv =====
// Shared compare unit: sees one stored process per cycle and keeps the best
// runnable one plus the earliest future arrival. Depends on srtf_pkg.
module srtf_pick #(
    parameter int IDX_W = 4,
    parameter int CLK_W = 13
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       cand_valid,
    input  logic [IDX_W-1:0]           cand_idx,
    input  logic [srtf_pkg::ARR_W-1:0] cand_arr,
    input  logic [srtf_pkg::BUR_W-1:0] cand_rem,
    input  logic [CLK_W-1:0]           sim_clock,
    output srtf_pkg::pick_flags_t      flags,
    output logic [IDX_W-1:0]           best_idx,
    output logic [srtf_pkg::BUR_W-1:0] best_rem,
    output logic [srtf_pkg::ARR_W-1:0] next_arr
);
    import srtf_pkg::*;

    pick_flags_t          flags_reg, flags_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [BUR_W-1:0]     best_rem_reg, best_rem_next;
    logic [ARR_W-1:0]     best_arr_reg, best_arr_next;
    logic [ARR_W-1:0]     next_arr_reg, next_arr_next;
    logic                 unfinished;
    logic                 arrived;
    logic                 better;

    assign unfinished = (cand_rem != '0);
    assign arrived    = (CLK_W'(cand_arr) <= sim_clock);
    // Ties on remaining time go to earlier arrival; scan order covers lower index.
    assign better     = !flags_reg.found || (cand_rem < best_rem_reg) ||
                        ((cand_rem == best_rem_reg) && (cand_arr < best_arr_reg));

    always_comb
    begin
        flags_next    = flags_reg;
        best_idx_next = best_idx_reg;
        best_rem_next = best_rem_reg;
        best_arr_next = best_arr_reg;
        next_arr_next = next_arr_reg;
        if (clear)
        begin
            flags_next = '0;
        end
        else if (cand_valid && unfinished)
        begin
            if (arrived)
            begin
                if (better)
                begin
                    flags_next.found = 1'b1;
                    best_idx_next    = cand_idx;
                    best_rem_next    = cand_rem;
                    best_arr_next    = cand_arr;
                end
            end
            else if (!flags_reg.has_next || (cand_arr < next_arr_reg))
            begin
                flags_next.has_next = 1'b1;
                next_arr_next       = cand_arr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_rem_reg <= best_rem_next;
        best_arr_reg <= best_arr_next;
        next_arr_reg <= next_arr_next;
    end

    assign flags    = flags_reg;
    assign best_idx = best_idx_reg;
    assign best_rem = best_rem_reg;
    assign next_arr = next_arr_reg;

endmodule

// ===== sv/srtf_checker.sv =====
// Port-level checks for the SRTF schedule simulator, bound to the top level.
// Depends on srtf_pkg and srtf_schedule_simulator.
module srtf_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [srtf_pkg::ARR_W-1:0]      arrival_time,
    input logic [srtf_pkg::BUR_W-1:0]      burst_time,
    input logic                            last_process,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [srtf_pkg::IDX_OUT_W-1:0]  process_index,
    input logic [srtf_pkg::COMP_OUT_W-1:0] completion_time,
    input logic [srtf_pkg::TIME_OUT_W-1:0] turnaround_time,
    input logic [srtf_pkg::TIME_OUT_W-1:0] waiting_time,
    input logic                            last_result
);
    import srtf_pkg::*;

    // a stalled result holds its index, completion time and last flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(process_index) &&
                                       $stable(completion_time) && $stable(last_result)))
        else $error("result changed while stalled");

    // the closing transfer of a set starts the run, so loading stops
    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_process) |=> !in_ready)
        else $error("input still ready after closing transfer");

    // every burst is at least one unit, so waiting never equals turnaround
    a_wait_lt_tat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (turnaround_time != waiting_time))
        else $error("waiting time equals turnaround time");

    // after the final result no other result can follow at once
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_result) |=> !out_valid)
        else $error("result right after final result");

endmodule

bind srtf_schedule_simulator srtf_checker u_srtf_checker (.*);
